>>> rtl/u2u8_pkg.sv
package u2u8_pkg;

    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 24;
    localparam int CAP_W   = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register word index (paddr[2])
    localparam logic REG_CAPACITY   = 1'b0;
    localparam logic REG_COUNT_ONLY = 1'b1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd256;

    // surrogate tags in the top six bits of a unit
    localparam logic [5:0] TAG_HIGH_SURR = 6'b110110;
    localparam logic [5:0] TAG_LOW_SURR  = 6'b110111;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_TERM = 2'd2
    } kind_t;

    // one entry per accepted unit that leads to any work
    typedef struct packed {
        logic        flush;        // held high surrogate goes out as three bytes first
        logic [23:0] flush_bytes;  // byte 0 in the low bits
        kind_t       kind;
        logic [2:0]  len;          // 1..4 bytes for a character
        logic [31:0] bytes;        // byte 0 in the low bits
    } cmd_t;

    function automatic logic [23:0] enc_three(input logic [UNIT_W-1:0] u);
        enc_three = {2'b10, u[5:0], 2'b10, u[11:6], 4'b1110, u[15:12]};
    endfunction

endpackage

>>> rtl/utf16_to_utf8_encoder.sv
// path: queue, then the sequencer's entry register, then the output register on m_tvalid
// throughput: one output byte per cycle from the back sequencer while m_tready does not stall it;
// a character that is only counted or dropped sends no byte
// the queue between the classifier and the sequencer holds QUEUE_DEPTH entries
// reset: clears the held surrogate, the byte count, the stop flag and the queue;
// capacity returns to 256 and count_only to 0
module utf16_to_utf8_encoder
#(
    parameter int COUNT_BITS  = 24,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] code_unit
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [7:0] out_byte, [31:8] total_bytes
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [u2u8_pkg::PADDR_W-1:0]     paddr,
    input  logic [u2u8_pkg::PDATA_W-1:0]     pwdata,
    output logic [u2u8_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    logic [u2u8_pkg::CAP_W-1:0]   capacity_reg;
    logic                         count_only_reg;
    logic                         cfg_write;
    logic                         push;
    logic                         pop;
    logic                         q_empty;
    logic                         q_full;
    u2u8_pkg::cmd_t               push_cmd;
    u2u8_pkg::cmd_t               head;
    logic [7:0]                   out_byte;
    logic [23:0]                  total_bytes;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= u2u8_pkg::CAPACITY_RESET;
            count_only_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                u2u8_pkg::REG_CAPACITY:   capacity_reg   <= pwdata[u2u8_pkg::CAP_W-1:0];
                u2u8_pkg::REG_COUNT_ONLY: count_only_reg <= pwdata[0];
                default:                  capacity_reg   <= capacity_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            u2u8_pkg::REG_CAPACITY:   prdata = {16'h0, capacity_reg};
            u2u8_pkg::REG_COUNT_ONLY: prdata = {31'h0, count_only_reg};
            default:                  prdata = '0;
        endcase
    end

    u2u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (s_tvalid),
        .code_unit  (s_tdata),
        .queue_full (q_full),
        .unit_ready (s_tready),
        .push       (push),
        .cmd        (push_cmd)
    );

    u2u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    u2u8_back #(.COUNT_BITS(COUNT_BITS)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .capacity    (capacity_reg),
        .count_only  (count_only_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .total_bytes (total_bytes),
        .last        (m_tlast)
    );

    assign m_tdata = {total_bytes, out_byte};

endmodule

>>> rtl/u2u8_front.sv
module u2u8_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           unit_valid,
    input  logic [u2u8_pkg::UNIT_W-1:0]    code_unit,
    input  logic                           queue_full,
    output logic                           unit_ready,
    output logic                           push,
    output u2u8_pkg::cmd_t                 cmd
);

    logic [u2u8_pkg::UNIT_W-1:0] held_high_reg;
    logic [u2u8_pkg::UNIT_W-1:0] held_high_next;
    logic                        held_valid_reg;
    logic                        held_valid_next;
    logic                        accept;
    logic                        is_low;
    logic                        is_high;
    logic [10:0]                 pair_upper;
    logic [20:0]                 code_point;

    assign unit_ready = !queue_full;
    assign accept     = unit_valid && unit_ready;
    assign is_low     = code_unit[15:10] == u2u8_pkg::TAG_LOW_SURR;
    assign is_high    = code_unit[15:10] == u2u8_pkg::TAG_HIGH_SURR;
    assign pair_upper = {1'b0, held_high_reg[9:0]} + 11'h040;
    assign code_point = {pair_upper[10:0], code_unit[9:0]};

    always_comb
    begin
        cmd             = '0;
        cmd.kind        = u2u8_pkg::KIND_NONE;
        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        if (held_valid_reg && is_low)
        begin
            cmd.kind        = u2u8_pkg::KIND_CHAR;
            cmd.len         = 3'd4;
            cmd.bytes       = {2'b10, code_point[5:0], 2'b10, code_point[11:6],
                               2'b10, code_point[17:12], 5'b11110, code_point[20:18]};
            held_valid_next = 1'b0;
            held_high_next  = '0;
        end
        else
        begin
            cmd.flush       = held_valid_reg;
            cmd.flush_bytes = u2u8_pkg::enc_three(held_high_reg);
            held_valid_next = 1'b0;
            held_high_next  = '0;
            if (code_unit == '0)
            begin
                cmd.kind = u2u8_pkg::KIND_TERM;
            end
            else if (code_unit[15:7] == '0)
            begin
                cmd.kind  = u2u8_pkg::KIND_CHAR;
                cmd.len   = 3'd1;
                cmd.bytes = {24'h0, code_unit[7:0]};
            end
            else if (code_unit[15:11] == '0)
            begin
                cmd.kind  = u2u8_pkg::KIND_CHAR;
                cmd.len   = 3'd2;
                cmd.bytes = {16'h0, 2'b10, code_unit[5:0], 3'b110, code_unit[10:6]};
            end
            else if (is_high)
            begin
                held_valid_next = 1'b1;
                held_high_next  = code_unit;
            end
            else
            begin
                cmd.kind  = u2u8_pkg::KIND_CHAR;
                cmd.len   = 3'd3;
                cmd.bytes = {8'h0, u2u8_pkg::enc_three(code_unit)};
            end
        end
    end

    assign push = accept && (cmd.flush || cmd.kind != u2u8_pkg::KIND_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_high_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_high_reg  <= held_high_next;
            held_valid_reg <= held_valid_next;
        end
    end

    held_is_high_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> held_high_reg[15:10] == u2u8_pkg::TAG_HIGH_SURR)
        else $error("held unit is not a high surrogate");

endmodule

>>> rtl/u2u8_queue.sv
module u2u8_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2u8_pkg::cmd_t push_cmd,
    input  logic           pop,
    output u2u8_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u8_pkg::cmd_t   entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = fill_reg == '0;
    assign full  = fill_reg == CW'(DEPTH);

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overrun");

    no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underrun");

endmodule

>>> rtl/u2u8_back.sv
module u2u8_back
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  u2u8_pkg::cmd_t                     head,
    input  logic                               empty,
    output logic                               pop,
    input  logic [u2u8_pkg::CAP_W-1:0]         capacity,
    input  logic                               count_only,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]        out_byte,
    output logic [u2u8_pkg::TOTAL_W-1:0]       total_bytes,
    output logic                               last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    u2u8_pkg::cmd_t                    ent_reg;
    u2u8_pkg::cmd_t                    ent_next;
    logic                              slot_reg;      // 0: flushed high surrogate, 1: main
    logic                              slot_next;
    logic [1:0]                        idx_reg;
    logic [1:0]                        idx_next;
    logic [COUNT_BITS-1:0]             count_reg;
    logic [COUNT_BITS-1:0]             count_next;
    logic                              stopped_reg;
    logic                              stopped_next;
    logic                              ovalid_reg;
    logic                              ovalid_next;
    logic [u2u8_pkg::BYTE_W-1:0]       obyte_reg;
    logic [u2u8_pkg::BYTE_W-1:0]       obyte_next;
    logic [u2u8_pkg::TOTAL_W-1:0]      ototal_reg;
    logic [u2u8_pkg::TOTAL_W-1:0]      ototal_next;
    logic                              olast_reg;
    logic                              olast_next;

    logic                              out_free;
    logic [2:0]                        cur_len;
    logic [31:0]                       cur_bytes;
    logic                              cur_term;
    logic [COUNT_BITS:0]               sum;
    logic [COUNT_BITS-1:0]             sum_sat;
    logic                              fits;
    logic                              char_done;
    logic                              ent_done;
    logic                              emit_term;
    logic [COUNT_BITS+u2u8_pkg::TOTAL_W-1:0] count_ext;

    assign out_free  = !ovalid_reg || out_ready;
    assign cur_len   = slot_reg ? ent_reg.len : 3'd3;
    assign cur_bytes = slot_reg ? ent_reg.bytes : {8'h0, ent_reg.flush_bytes};
    assign cur_term  = slot_reg && ent_reg.kind == u2u8_pkg::KIND_TERM;
    assign sum       = {1'b0, count_reg} + (COUNT_BITS+1)'(cur_len);
    assign sum_sat   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    // room for the character and the terminator
    assign fits      = sum < (COUNT_BITS+1)'(capacity);
    assign count_ext = {{u2u8_pkg::TOTAL_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        obyte_next   = obyte_reg;
        ototal_next  = ototal_reg;
        olast_next   = olast_reg;
        char_done    = 1'b0;
        emit_term    = 1'b0;
        pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                char_done = 1'b0;
            end
            ST_CHECK:
            begin
                if (cur_term)
                begin
                    if (out_free)
                    begin
                        ovalid_next  = 1'b1;
                        obyte_next   = '0;
                        ototal_next  = count_ext[u2u8_pkg::TOTAL_W-1:0];
                        olast_next   = 1'b1;
                        count_next   = '0;
                        stopped_next = 1'b0;
                        emit_term    = 1'b1;
                        char_done    = 1'b1;
                    end
                end
                else if (count_only)
                begin
                    count_next = sum_sat;
                    char_done  = 1'b1;
                end
                else if (stopped_reg)
                begin
                    char_done = 1'b1;
                end
                else if (!fits)
                begin
                    stopped_next = 1'b1;
                    char_done    = 1'b1;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = cur_bytes[7:0];
                    ototal_next = '0;
                    olast_next  = 1'b0;
                    count_next  = sum_sat;
                    if (cur_len == 3'd1)
                    begin
                        char_done = 1'b1;
                    end
                    else
                    begin
                        idx_next   = 2'd1;
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = cur_bytes[{idx_reg, 3'b000} +: 8];
                    ototal_next = '0;
                    olast_next  = 1'b0;
                    idx_next    = idx_reg + 2'd1;
                    if ({1'b0, idx_reg} == cur_len - 3'd1)
                    begin
                        char_done = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ent_done = char_done && (slot_reg || ent_reg.kind == u2u8_pkg::KIND_NONE);
        if (char_done && !ent_done)
        begin
            slot_next  = 1'b1;
            idx_next   = 2'd0;
            state_next = ST_CHECK;
        end
        else if (ent_done || state_reg == ST_IDLE)
        begin
            idx_next = 2'd0;
            if (!empty)
            begin
                pop        = 1'b1;
                ent_next   = head;
                slot_next  = !head.flush;
                state_next = ST_CHECK;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        obyte_reg  <= obyte_next;
        ototal_reg <= ototal_next;
        olast_reg  <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= 1'b0;
            idx_reg     <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign total_bytes = ototal_reg;
    assign last        = olast_reg;

    count_clears_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        emit_term |=> count_reg == '0 && !stopped_reg)
        else $error("state not cleared after terminator");

    send_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEND |-> ({1'b0, idx_reg} < cur_len && !cur_term))
        else $error("byte index beyond character length");

endmodule
